>>> hw/rtl/die_pkg.sv
// Shared types and constants for the dead instruction eliminator.
// No dependencies; every other file of the block but die_out_if refers to this package.
package die_pkg;

  localparam int REG_W        = 8;    // width of a register number field
  localparam int ARG_N        = 4;    // argument fields carried by one beat
  localparam int MAX_ARGS     = 4;    // arguments the scan considers
  localparam int SET_N        = ARG_N + 1;
  localparam int NUM_REGS_DEF = 256;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_INSTR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ORD  = 3'd0,
    KIND_CALL = 3'd1,
    KIND_SET  = 3'd2,
    KIND_OUT  = 3'd3,
    KIND_NOP  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]                  command;
    logic [REG_W-1:0]            mark_reg;
    logic [2:0]                  op_kind;
    logic                        has_out_reg;
    logic [REG_W-1:0]            out_reg;
    logic [ARG_N-1:0]            arg_reg_mask;
    logic [ARG_N-1:0][REG_W-1:0] arg_reg;
  } item_t;

  // Update applied to the live map when an item retires.
  typedef struct packed {
    logic                        clear_all;
    logic                        clr_vld;
    logic [REG_W-1:0]            clr_reg;
    logic [SET_N-1:0]            set_vld;
    logic [SET_N-1:0][REG_W-1:0] set_reg;
  } map_upd_t;

endpackage

>>> hw/rtl/die_in_if.sv
// Input channel of the dead instruction eliminator: valid/ready plus item fields.
// Depends on die_pkg for the field widths.
interface die_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [die_pkg::REG_W-1:0] mark_reg;
  logic [2:0]               op_kind;
  logic                     has_out_reg;
  logic [die_pkg::REG_W-1:0] out_reg;
  logic [die_pkg::ARG_N-1:0] arg_reg_mask;
  logic [die_pkg::REG_W-1:0] arg0_reg;
  logic [die_pkg::REG_W-1:0] arg1_reg;
  logic [die_pkg::REG_W-1:0] arg2_reg;
  logic [die_pkg::REG_W-1:0] arg3_reg;

  modport source (
    output valid, command, mark_reg, op_kind, has_out_reg, out_reg,
           arg_reg_mask, arg0_reg, arg1_reg, arg2_reg, arg3_reg,
    input  ready
  );
  modport sink (
    input  valid, command, mark_reg, op_kind, has_out_reg, out_reg,
           arg_reg_mask, arg0_reg, arg1_reg, arg2_reg, arg3_reg,
    output ready
  );
endinterface

>>> hw/rtl/die_out_if.sv
// Result channel of the dead instruction eliminator: valid/ready plus make_nop.
// No dependencies.
interface die_out_if;
  logic valid;
  logic ready;
  logic make_nop;

  modport source (output valid, make_nop, input ready);
  modport sink (input valid, make_nop, output ready);
endinterface

>>> hw/rtl/die_live_map.sv
// Per-register live map held in flip-flops, with one lookup port and a
// registered clear / mark update. Depends on die_pkg.
module die_live_map #(
  parameter int NUM_REGS = die_pkg::NUM_REGS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [die_pkg::REG_W-1:0]  look_reg,
  output logic                       look_live,
  input  logic                       upd_en,
  input  die_pkg::map_upd_t          upd
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [NUM_REGS-1:0] live_r;
  logic [NUM_REGS-1:0] live_nxt;
  logic [31:0]         look_ext;
  logic [IDX_W-1:0]    look_idx;

  assign look_ext = 32'(look_reg);
  assign look_idx = look_ext[IDX_W-1:0];
  // Register numbers beyond the map read as dead.
  assign look_live = (look_ext < 32'(NUM_REGS)) ? live_r[look_idx] : 1'b0;

  always_comb begin
    logic clr_hit;
    logic set_hit;
    for (int i = 0; i < NUM_REGS; i++) begin
      clr_hit = upd.clr_vld && (32'(upd.clr_reg) == 32'(i));
      set_hit = 1'b0;
      for (int k = 0; k < die_pkg::SET_N; k++) begin
        if (upd.set_vld[k] && (32'(upd.set_reg[k]) == 32'(i))) begin
          set_hit = 1'b1;
        end
      end
      // The output register is cleared before the arguments are marked.
      live_nxt[i] = upd.clear_all ? 1'b0 : ((live_r[i] & ~clr_hit) | set_hit);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (upd_en) begin
      live_r <= live_nxt;
    end
  end

endmodule

>>> hw/rtl/die_decide.sv
// Decision logic for one item: the no-op verdict and the live map update.
// Purely combinational; depends on die_pkg.
module die_decide (
  input  die_pkg::item_t    item,
  input  logic              out_live,
  output logic              has_result,
  output logic              make_nop,
  output die_pkg::map_upd_t upd
);

  logic nop;

  always_comb begin
    nop = (item.op_kind == die_pkg::KIND_NOP);
    if (item.has_out_reg) begin
      if (!out_live && (item.op_kind != die_pkg::KIND_CALL)) begin
        nop = 1'b1;
      end
    end else if (!(item.op_kind inside {die_pkg::KIND_CALL, die_pkg::KIND_SET,
                                        die_pkg::KIND_OUT})) begin
      nop = 1'b1;
    end
  end

  always_comb begin
    upd            = '0;
    has_result     = 1'b0;
    make_nop       = nop;
    upd.clr_reg    = item.out_reg;
    upd.set_reg[0] = item.mark_reg;
    for (int k = 0; k < die_pkg::ARG_N; k++) begin
      upd.set_reg[k+1] = item.arg_reg[k];
    end
    case (item.command)
      die_pkg::CMD_BEGIN: begin
        upd.clear_all = 1'b1;
      end
      die_pkg::CMD_MARK: begin
        upd.set_vld[0] = 1'b1;
      end
      die_pkg::CMD_INSTR: begin
        has_result  = 1'b1;
        upd.clr_vld = item.has_out_reg;
        for (int k = 0; k < die_pkg::ARG_N; k++) begin
          upd.set_vld[k+1] = !nop && item.arg_reg_mask[k] && (k < die_pkg::MAX_ARGS);
        end
      end
      default: begin
        upd = upd;
      end
    endcase
  end

endmodule

>>> hw/rtl/dead_instruction_eliminator.sv
// Dead instruction eliminator top level: input register, decision logic,
// live map and result register. Depends on die_pkg, die_in_if, die_out_if,
// die_live_map and die_decide.
//
// Beats arrive as a begin beat that clears the live map, mark beats for the
// registers live at block exit, then one instruction beat per instruction
// from last to first. Each instruction beat yields one make_nop result; other
// beats yield none and a command of 3 is ignored. The block takes one beat
// per clock while not stalled: a beat is held in the input register, where
// the live map is looked up and updated, and its result is then loaded into
// the output register. The live map is held in NUM_REGS flip-flops and is
// reset to all dead. Register numbers at or above NUM_REGS read as dead and
// are never marked. The input side only stalls when a result waits in the
// output register and the sink is not taking it.
module dead_instruction_eliminator #(
  parameter int NUM_REGS = die_pkg::NUM_REGS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  die_in_if.sink   in_s,
  die_out_if.source out_s
);

  logic              in_vld_r;
  logic              in_vld_nxt;
  die_pkg::item_t    in_item_r;
  die_pkg::item_t    in_item_nxt;
  logic              out_vld_r;
  logic              out_vld_nxt;
  logic              out_nop_r;
  logic              out_nop_nxt;

  logic              out_live;
  logic              has_result;
  logic              make_nop;
  die_pkg::map_upd_t upd;
  logic              fire;
  logic              out_free;
  logic              in_ready;

  assign out_free = !out_vld_r || out_s.ready;
  // Beats without a result retire regardless of the output side.
  assign fire     = in_vld_r && (!has_result || out_free);
  assign in_ready = !in_vld_r || fire;
  assign in_s.ready = in_ready;

  always_comb begin
    in_item_nxt              = in_item_r;
    in_vld_nxt               = in_vld_r;
    if (in_ready) begin
      in_vld_nxt               = in_s.valid;
      in_item_nxt.command      = in_s.command;
      in_item_nxt.mark_reg     = in_s.mark_reg;
      in_item_nxt.op_kind      = in_s.op_kind;
      in_item_nxt.has_out_reg  = in_s.has_out_reg;
      in_item_nxt.out_reg      = in_s.out_reg;
      in_item_nxt.arg_reg_mask = in_s.arg_reg_mask;
      in_item_nxt.arg_reg[0]   = in_s.arg0_reg;
      in_item_nxt.arg_reg[1]   = in_s.arg1_reg;
      in_item_nxt.arg_reg[2]   = in_s.arg2_reg;
      in_item_nxt.arg_reg[3]   = in_s.arg3_reg;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nop_nxt = out_nop_r;
    if (fire && has_result) begin
      out_vld_nxt = 1'b1;
      out_nop_nxt = make_nop;
    end else if (out_s.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_nop_r <= out_nop_nxt;
  end

  assign out_s.valid    = out_vld_r;
  assign out_s.make_nop = out_nop_r;

  die_live_map #(
    .NUM_REGS (NUM_REGS)
  ) u_live_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .look_reg  (in_item_r.out_reg),
    .look_live (out_live),
    .upd_en    (fire),
    .upd       (upd)
  );

  die_decide u_decide (
    .item       (in_item_r),
    .out_live   (out_live),
    .has_result (has_result),
    .make_nop   (make_nop),
    .upd        (upd)
  );

endmodule
